// ===== rtl/tta_pkg.sv =====
`timescale 1ns / 1ps

package tta_pkg;

    // ascii codes used by the parser
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;

    // fixed teredo prefix groups
    localparam logic [15:0] PREFIX_HI   = 16'h2001;
    localparam logic [15:0] PREFIX_LO   = 16'h0000;

    // group positions of interest
    localparam logic [2:0] GRP_PREFIX_HI = 3'd0;
    localparam logic [2:0] GRP_PREFIX_LO = 3'd1;
    localparam logic [2:0] GRP_PORT      = 3'd5;
    localparam logic [2:0] GRP_ADDR_HI   = 3'd6;
    localparam logic [2:0] GRP_LAST      = 3'd7;

    localparam logic [2:0] MAX_DIGITS    = 3'd4;

    // classified character
    typedef struct packed {
        logic       is_hex;
        logic       is_colon;
        logic [3:0] digit;
    } t_char_info;

    // one decoded result
    typedef struct packed {
        logic        valid_res;
        logic [31:0] client_ipv4;
        logic [15:0] client_port;
    } t_result;

endpackage

// ===== rtl/tta_char_class.sv =====
`timescale 1ns / 1ps

module tta_char_class (
    input  logic [7:0]          i_char,
    output tta_pkg::t_char_info o_info
);
    import tta_pkg::*;

    logic w_num;
    logic w_low;
    logic w_up;

    // range checks for decimal and both letter cases
    assign w_num = (i_char >= CHAR_ZERO)  && (i_char <= CHAR_NINE);
    assign w_low = (i_char >= CHAR_LOW_A) && (i_char <= CHAR_LOW_F);
    assign w_up  = (i_char >= CHAR_UP_A)  && (i_char <= CHAR_UP_F);

    // letters have low nibble 1..6, value is nibble plus nine
    always_comb begin
        o_info.is_hex   = w_num | w_low | w_up;
        o_info.is_colon = (i_char == CHAR_COLON);
        if (w_num) begin
            o_info.digit = i_char[3:0];
        end else begin
            o_info.digit = i_char[3:0] + 4'd9;
        end
    end

endmodule

// ===== rtl/tta_parse.sv =====
`timescale 1ns / 1ps

module tta_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_last,
    input  tta_pkg::t_char_info i_info,
    output tta_pkg::t_result    o_result
);
    import tta_pkg::*;

    logic [2:0]  r_groups;
    logic [2:0]  r_digits;
    logic [15:0] r_group_val;
    logic [15:0] r_port_grp;
    logic [15:0] r_addr_hi_grp;
    logic        r_rejected;

    logic [2:0]  n_groups;
    logic [2:0]  n_digits;
    logic [15:0] n_group_val;
    logic [15:0] n_port_grp;
    logic [15:0] n_addr_hi_grp;
    logic        n_rejected;
    logic        w_rej_end;

    // per-character update of the group state
    always_comb begin
        n_groups      = r_groups;
        n_digits      = r_digits;
        n_group_val   = r_group_val;
        n_port_grp    = r_port_grp;
        n_addr_hi_grp = r_addr_hi_grp;
        n_rejected    = r_rejected;
        if (!r_rejected) begin
            if (i_info.is_colon) begin
                // colon closes a non-empty group unless the eighth one is open
                if (r_groups == GRP_LAST || r_digits == 3'd0) begin
                    n_rejected = 1'b1;
                end else begin
                    if (r_groups == GRP_PREFIX_HI && r_group_val != PREFIX_HI) begin
                        n_rejected = 1'b1;
                    end
                    if (r_groups == GRP_PREFIX_LO && r_group_val != PREFIX_LO) begin
                        n_rejected = 1'b1;
                    end
                    if (r_groups == GRP_PORT) begin
                        n_port_grp = r_group_val;
                    end
                    if (r_groups == GRP_ADDR_HI) begin
                        n_addr_hi_grp = r_group_val;
                    end
                    n_groups    = r_groups + 3'd1;
                    n_digits    = 3'd0;
                    n_group_val = 16'h0000;
                end
            end else if (!i_info.is_hex || r_digits >= MAX_DIGITS) begin
                n_rejected = 1'b1;
            end else begin
                n_group_val = {r_group_val[11:0], i_info.digit};
                n_digits    = r_digits + 3'd1;
            end
        end
    end

    // end of string: eighth group must be open and non-empty
    assign w_rej_end = n_rejected || (n_groups != GRP_LAST) || (n_digits == 3'd0);

    always_comb begin
        if (w_rej_end) begin
            o_result = '0;
        end else begin
            o_result.valid_res   = 1'b1;
            o_result.client_port = ~n_port_grp;
            o_result.client_ipv4 = {~n_addr_hi_grp, ~n_group_val};
        end
    end

    // state registers, cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_groups      <= '0;
            r_digits      <= '0;
            r_group_val   <= '0;
            r_port_grp    <= '0;
            r_addr_hi_grp <= '0;
            r_rejected    <= 1'b0;
        end else if (i_fire) begin
            r_groups      <= n_groups;
            r_digits      <= n_digits;
            r_group_val   <= n_group_val;
            r_port_grp    <= n_port_grp;
            r_addr_hi_grp <= n_addr_hi_grp;
            r_rejected    <= n_rejected;
        end
    end

endmodule

// ===== rtl/teredo_text_address_decoder_core.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// s       | in  | tvalid / tready    | tdata[7:0] character, tlast last
// m       | out | tvalid / tready    | tdata[15:0] client_port, tdata[47:16] client_ipv4,
//         |     |                    | tuser valid_res
//
// one character per cycle while no last beat is blocked; a beat is registered, then
// decoded by the group state logic, and a last beat loads the result register.
// reset (synchronous, active low) clears the group state and both valid flags.
// only a last beat waits on a full result register; other beats wait only behind it.

module teredo_text_address_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [15:0] client_port, [47:16] client_ipv4
    output logic        o_m_tuser    // [0] valid_res
);
    import tta_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_fire;
    t_char_info w_info;
    t_result    w_result;

    // a beat moves on unless it is a last beat facing a full result register
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    tta_char_class u_char_class (
        .i_char (r_in_char),
        .o_info (w_info)
    );

    tta_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_last   (r_in_last),
        .i_info   (w_info),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.client_ipv4, r_out.client_port};
    assign o_m_tuser  = r_out.valid_res;

    // rejected results carry zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 48'h0))
        else $error("rejected result with nonzero fields");

    // input side only stalls behind a pending last beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_in_last && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked last beat");

    // a blocked last beat and its pending result are both kept
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !i_m_tready)
        |=> (r_in_valid && r_in_last && r_out_valid))
        else $error("blocked last beat or pending result lost");

endmodule

// ===== test/tb_teredo_text_address_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_teredo_text_address_decoder_core;
    import tta_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 400;
    localparam int CHAR_TARGET  = 1220;

    // one character beat waiting to be sent
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] character
    logic        i_s_tlast  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;            // [15:0] client_port, [47:16] client_ipv4
    logic        o_m_tuser;            // [0] valid_res

    teredo_text_address_decoder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // character queue for the driver and decoded results still owed by the block
    t_char_beat  pending_chars[$];
    t_result     decoded_q[$];
    logic [7:0]  text_q[$];

    // parser state mirrored on the testbench side
    logic [3:0]  groups_done;
    logic [2:0]  group_digits;
    logic [15:0] group_acc;
    logic [15:0] port_grp;
    logic [15:0] ipv4_hi_grp;
    logic [15:0] ipv4_lo_grp;
    logic        addr_bad;

    int          mismatches   = 0;
    int          chars_taken  = 0;
    int          chars_total  = 0;
    int          idle_cycles  = 0;
    logic        in_taken     = 1'b0;
    logic        out_taken    = 1'b0;
    logic        stim_go      = 1'b0;
    t_result     want;

    // sender burst state
    int          burst_left   = 0;
    int          gap_left     = 0;
    t_char_beat  beat;

    // receiver stall state
    int          rx_mode      = 0;
    int          rx_phase     = 0;
    int          rx_cycle     = 0;
    int          hold_left    = 0;
    logic        held_once    = 1'b0;
    logic        rx_ready;

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // value of a hex digit, bit 4 set for anything else
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) return {1'b0, 4'(ch - CHAR_ZERO)};
        if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_F) return {1'b0, 4'(ch - CHAR_LOW_A + 8'd10)};
        if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) return {1'b0, 4'(ch - CHAR_UP_A + 8'd10)};
        return 5'h10;
    endfunction

    task automatic clear_parser();
        groups_done  = '0;
        group_digits = '0;
        group_acc    = '0;
        port_grp     = '0;
        ipv4_hi_grp  = '0;
        ipv4_lo_grp  = '0;
        addr_bad     = 1'b0;
    endtask

    // close the group in progress, checking the prefix and keeping groups 5 to 7
    task automatic end_group();
        if (group_digits == 3'd0 || groups_done > 4'd7) begin
            addr_bad = 1'b1;
        end else begin
            if (groups_done == GRP_PREFIX_HI && group_acc != PREFIX_HI) addr_bad = 1'b1;
            if (groups_done == GRP_PREFIX_LO && group_acc != PREFIX_LO) addr_bad = 1'b1;
            if (groups_done == GRP_PORT) port_grp = group_acc;
            if (groups_done == GRP_ADDR_HI) ipv4_hi_grp = group_acc;
            if (groups_done == GRP_LAST) ipv4_lo_grp = group_acc;
            groups_done  = groups_done + 4'd1;
            group_digits = '0;
            group_acc    = '0;
        end
    endtask

    // advance the parser by one character, queue the decoded result on the last one
    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [4:0] nib;
        t_result    res;
        if (!addr_bad) begin
            if (ch == CHAR_COLON) begin
                if (groups_done >= GRP_LAST) addr_bad = 1'b1;
                else end_group();
            end else begin
                nib = hex_nibble(ch);
                if (nib[4] || group_digits >= MAX_DIGITS) begin
                    addr_bad = 1'b1;
                end else begin
                    group_acc    = {group_acc[11:0], nib[3:0]};
                    group_digits = group_digits + 3'd1;
                end
            end
        end
        if (last) begin
            if (!addr_bad) begin
                if (groups_done != GRP_LAST) addr_bad = 1'b1;
                else end_group();
            end
            res = '0;
            if (!addr_bad) begin
                res.valid_res   = 1'b1;
                res.client_port = ~port_grp;
                res.client_ipv4 = {~ipv4_hi_grp, ~ipv4_lo_grp};
            end
            decoded_q.push_back(res);
            clear_parser();
        end
    endtask

    // hex digit in random case
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return CHAR_ZERO + 8'(d);
        if ($urandom_range(0, 1) == 0) return CHAR_LOW_A + 8'(d - 4'd10);
        return CHAR_UP_A + 8'(d - 4'd10);
    endfunction

    // low ndig nibbles of val, a fifth digit comes out random
    task automatic put_group(input logic [15:0] val, input int ndig);
        for (int k = ndig - 1; k >= 0; k--) begin
            if (k < 4) text_q.push_back(hex_char(val[4*k +: 4]));
            else text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
    endtask

    // address text with ngroups groups; long_grp gets five digits,
    // prefix_err 1 spoils the first group and 2 the second
    task automatic build_addr(input int ngroups, input int long_grp, input int prefix_err);
        logic [15:0] val;
        int          ndig;
        text_q.delete();
        for (int g = 0; g < ngroups; g++) begin
            if (g > 0) text_q.push_back(CHAR_COLON);
            if (g == 0) begin
                val  = (prefix_err == 1) ? 16'($urandom_range(0, 16'hFFFF)) : PREFIX_HI;
                ndig = 4;
            end else if (g == 1) begin
                val  = (prefix_err == 2) ? 16'($urandom_range(1, 16'hFFFF)) : PREFIX_LO;
                ndig = (prefix_err == 2) ? 4 : $urandom_range(1, 4);
            end else begin
                case ($urandom_range(0, 7))
                    0:       val = 16'hFFFF;
                    1:       val = 16'h0000;
                    default: val = 16'($urandom_range(0, 16'hFFFF));
                endcase
                ndig = (val == 16'hFFFF) ? 4 : $urandom_range(1, 4);
            end
            if (g == long_grp) ndig = 5;
            put_group(val, ndig);
        end
    endtask

    task automatic send_text();
        t_char_beat b;
        foreach (text_q[i]) begin
            b.ch   = text_q[i];
            b.last = (i == text_q.size() - 1);
            pending_chars.push_back(b);
        end
    endtask

    task automatic send_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
        send_text();
    endtask

    // stimulus, reset and end of run
    initial begin
        int kind;
        int n;
        clear_parser();

        // directed: extremes of the groups, empty groups, bad bytes
        send_str("2001:0:0:0:0:0:fFfF:0");
        send_str(":");
        send_str("2001::");
        text_q.delete();
        text_q.push_back(8'h00);
        send_text();
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text();

        // random: mostly well-formed addresses, the rest broken or noise
        while (pending_chars.size() < CHAR_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
                build_addr(8, -1, 0);
            end else begin
                case (kind)
                    11: build_addr(9, -1, 0);
                    12: build_addr($urandom_range(1, 7), -1, 0);
                    13: build_addr(8, -1, $urandom_range(1, 2));
                    14: build_addr(8, $urandom_range(0, 7), 0);
                    15: begin
                        build_addr(8, -1, 0);
                        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
                    end
                    16: begin
                        build_addr(8, -1, 0);
                        text_q.delete($urandom_range(0, text_q.size() - 1));
                    end
                    17: begin
                        build_addr(8, -1, 0);
                        text_q.insert($urandom_range(0, text_q.size()), CHAR_COLON);
                    end
                    default: begin
                        text_q.delete();
                        n = $urandom_range(1, 24);
                        repeat (n) begin
                            case ($urandom_range(0, 3))
                                0:       text_q.push_back(8'($urandom_range(0, 255)));
                                1:       text_q.push_back(CHAR_COLON);
                                default: text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                            endcase
                        end
                    end
                endcase
            end
            send_text();
        end
        chars_total = pending_chars.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        stim_go = 1'b1;

        while (chars_taken != chars_total || decoded_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // sender: bursts of beats with random gaps
    always @(negedge i_clk) begin
        if (stim_go && (!i_s_tvalid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                beat = pending_chars.pop_front();
                i_s_tdata  <= beat.ch;
                i_s_tlast  <= beat.last;
                i_s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall modes, one long hold-off
    always @(negedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        if (rx_phase == 0) begin
            rx_mode  = $urandom_range(0, 3);
            rx_phase = $urandom_range(20, 120);
        end else begin
            rx_phase = rx_phase - 1;
        end
        if (!held_once && chars_taken >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rx_ready  = 1'b0;
        end else begin
            case (rx_mode)
                0:       rx_ready = 1'b1;
                1:       rx_ready = ($urandom_range(0, 1) == 0);
                2:       rx_ready = ($urandom_range(0, 3) == 0);
                default: rx_ready = (rx_cycle % 5 != 3);
            endcase
        end
        i_m_tready <= rx_ready;
    end

    // monitor: predict on input beats, compare output beats, watchdog
    always @(posedge i_clk) begin
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                decode_char(i_s_tdata, i_s_tlast);
                in_taken    = 1'b1;
                chars_taken = chars_taken + 1;
            end

            if (o_m_tvalid && i_m_tready) begin
                out_taken = 1'b1;
                if (decoded_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: result beat with none expected: tuser=%0b tdata=%h",
                             $time, o_m_tuser, o_m_tdata);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_m_tuser !== want.valid_res) begin
                        mismatches = mismatches + 1;
                        $display("%0t: valid_res expected %0b actual %0b",
                                 $time, want.valid_res, o_m_tuser);
                    end
                    if (o_m_tdata[15:0] !== want.client_port) begin
                        mismatches = mismatches + 1;
                        $display("%0t: client_port expected %h actual %h",
                                 $time, want.client_port, o_m_tdata[15:0]);
                    end
                    if (o_m_tdata[47:16] !== want.client_ipv4) begin
                        mismatches = mismatches + 1;
                        $display("%0t: client_ipv4 expected %h actual %h",
                                 $time, want.client_ipv4, o_m_tdata[47:16]);
                    end
                end
            end

            if (in_taken || out_taken) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
